[src/reflect_refract_direction_top_assert.svh]
// Assertion macros used by the reflect/refract direction top level.
`ifndef REFLECT_REFRACT_DIRECTION_TOP_ASSERT_SVH
`define REFLECT_REFRACT_DIRECTION_TOP_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define RRD_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("reflect/refract direction assertion failed");

// An implication checked at every clock edge outside reset.
`define RRD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("reflect/refract direction implication failed");

`endif

[src/rrd_pkg.sv]
// Types and constants of the reflect/refract direction unit.
`timescale 1ns / 1ps
`default_nettype none

package rrd_pkg;

  localparam int unsigned VEC_W    = 16;
  localparam int unsigned ACC_W    = 32;
  localparam int unsigned WIDE_W   = 64;
  localparam int unsigned QUOT_W   = 17;
  localparam int unsigned LANES    = 3;

  typedef enum logic {
    OP_REFLECT = 1'b0,
    OP_REFRACT = 1'b1
  } op_e;

  typedef logic signed [VEC_W-1:0] vec_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  // Per-transaction control that rides from the Snell test stage to the output.
  typedef struct packed {
    op_e                op;
    logic               tir;
    vec_t [LANES-1:0]   refl;
  } tag_t;

  typedef struct packed {
    tag_t               tag;
    acc_t               ec;
    acc_t [LANES-1:0]   eiq;
    vec_t [LANES-1:0]   nv;
  } sqrt1_side_t;

  typedef struct packed {
    tag_t                          tag;
    logic [LANES-1:0]              neg;
    logic [LANES-1:0][ACC_W-1:0]   mag;
  } sqrt2_side_t;

  typedef struct packed {
    tag_t               tag;
    logic [LANES-1:0]   neg;
    logic               zero_len;
    logic [LANES-1:0]   over;
  } div_side_t;

endpackage

`default_nettype wire

[src/rrd_if.sv]
// Valid/ready channel interfaces for ray items and direction results.
`timescale 1ns / 1ps
`default_nettype none

interface rrd_in_if;
  logic               valid;
  logic               ready;
  rrd_pkg::op_e       op;
  rrd_pkg::vec_t      incident_x;
  rrd_pkg::vec_t      incident_y;
  rrd_pkg::vec_t      incident_z;
  rrd_pkg::vec_t      normal_x;
  rrd_pkg::vec_t      normal_y;
  rrd_pkg::vec_t      normal_z;
  logic [15:0]        index_ratio;

  modport source (output valid, op, incident_x, incident_y, incident_z,
                  normal_x, normal_y, normal_z, index_ratio, input ready);
  modport sink   (input valid, op, incident_x, incident_y, incident_z,
                  normal_x, normal_y, normal_z, index_ratio, output ready);
endinterface

interface rrd_out_if;
  logic               valid;
  logic               ready;
  rrd_pkg::vec_t      out_x;
  rrd_pkg::vec_t      out_y;
  rrd_pkg::vec_t      out_z;
  logic               total_reflection;

  modport source (output valid, out_x, out_y, out_z, total_reflection, input ready);
  modport sink   (input valid, out_x, out_y, out_z, total_reflection, output ready);
endinterface

`default_nettype wire

[src/rrd_isqrt_pipe.sv]
// Pipelined integer square root, one result bit per register stage.
`timescale 1ns / 1ps
`default_nettype none

module rrd_isqrt_pipe #(
  parameter int unsigned Width = 64,
  parameter int unsigned SideW = 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire logic                 valid_i,
  input  wire logic [Width-1:0]     x_i,
  input  wire logic [SideW-1:0]     side_i,
  output logic                      valid_o,
  output logic [Width/2-1:0]        root_o,
  output logic [SideW-1:0]          side_o
);

  localparam int unsigned Steps = Width / 2;

  logic [Width-1:0] x_q    [Steps];
  logic [Width-1:0] r_q    [Steps];
  logic             v_q    [Steps];
  logic [SideW-1:0] side_q [Steps];

  for (genvar k = 0; k < Steps; k++) begin : g_step
    localparam logic [Width-1:0] Bit = Width'(1) << (Width - 2 - 2 * k);
    logic [Width-1:0] x_in, r_in, x_d, r_d;
    logic             v_in;
    logic [SideW-1:0] s_in;

    if (k == 0) begin : g_first
      assign x_in = x_i;
      assign r_in = '0;
      assign v_in = valid_i;
      assign s_in = side_i;
    end else begin : g_next
      assign x_in = x_q[k-1];
      assign r_in = r_q[k-1];
      assign v_in = v_q[k-1];
      assign s_in = side_q[k-1];
    end

    always_comb begin
      if (x_in >= r_in + Bit) begin
        x_d = x_in - (r_in + Bit);
        r_d = (r_in >> 1) + Bit;
      end else begin
        x_d = x_in;
        r_d = r_in >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[k]    <= x_d;
        r_q[k]    <= r_d;
        side_q[k] <= s_in;
      end
    end
  end

  assign valid_o = v_q[Steps-1];
  assign root_o  = r_q[Steps-1][Width/2-1:0];
  assign side_o  = side_q[Steps-1];

endmodule

`default_nettype wire

[src/rrd_div_pipe.sv]
// Pipelined restoring divider, several lanes sharing one divisor.
`timescale 1ns / 1ps
`default_nettype none

module rrd_div_pipe #(
  parameter int unsigned Lanes = 3,
  parameter int unsigned NumW  = 64,
  parameter int unsigned DenW  = 32,
  parameter int unsigned QuotW = 17,
  parameter int unsigned SideW = 1
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          en_i,
  input  wire logic                          valid_i,
  input  wire logic [Lanes-1:0][NumW-1:0]    num_i,
  input  wire logic [DenW-1:0]               den_i,
  input  wire logic [SideW-1:0]              side_i,
  output logic                               valid_o,
  output logic [Lanes-1:0][QuotW-1:0]        quot_o,
  output logic [SideW-1:0]                   side_o
);

  logic [Lanes-1:0][NumW-1:0]  rem_q  [QuotW];
  logic [Lanes-1:0][QuotW-1:0] quot_q [QuotW];
  logic [DenW-1:0]             den_q  [QuotW];
  logic                        v_q    [QuotW];
  logic [SideW-1:0]            side_q [QuotW];

  for (genvar j = 0; j < QuotW; j++) begin : g_step
    localparam int unsigned Shift = QuotW - 1 - j;
    logic [Lanes-1:0][NumW-1:0]  rem_in, rem_d;
    logic [Lanes-1:0][QuotW-1:0] quot_in, quot_d;
    logic [DenW-1:0]             den_in;
    logic [NumW-1:0]             trial;
    logic                        v_in;
    logic [SideW-1:0]            s_in;

    if (j == 0) begin : g_first
      assign rem_in  = num_i;
      assign quot_in = '0;
      assign den_in  = den_i;
      assign v_in    = valid_i;
      assign s_in    = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign quot_in = quot_q[j-1];
      assign den_in  = den_q[j-1];
      assign v_in    = v_q[j-1];
      assign s_in    = side_q[j-1];
    end

    assign trial = {{(NumW - DenW){1'b0}}, den_in} << Shift;

    always_comb begin
      for (int l = 0; l < Lanes; l++) begin
        if (rem_in[l] >= trial) begin
          rem_d[l]  = rem_in[l] - trial;
          quot_d[l] = {quot_in[l][QuotW-2:0], 1'b1};
        end else begin
          rem_d[l]  = rem_in[l];
          quot_d[l] = {quot_in[l][QuotW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (en_i) begin
        v_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= rem_d;
        quot_q[j] <= quot_d;
        den_q[j]  <= den_in;
        side_q[j] <= s_in;
      end
    end
  end

  assign valid_o = v_q[QuotW-1];
  assign quot_o  = quot_q[QuotW-1];
  assign side_o  = side_q[QuotW-1];

endmodule

`default_nettype wire

[src/reflect_refract_direction_top.sv]
// Top level of the pipelined reflect/refract direction unit.
//
// Usage: ray items arrive on in_i (valid/ready); one result per item leaves on
// out_o (valid/ready) in the order the items were accepted. Op reflect returns
// i - 2(i.n)n, unnormalized. Op refract applies Snell's law, flags total
// internal reflection with a zero vector, and otherwise returns the refracted
// direction normalized to unit length. All vectors are signed fixed point
// with FRAC_BITS fraction bits; results saturate to 16 bits.
// On its way to its result an accepted transaction passes through six
// multiply/round stages, a 32-stage square root for cos(theta_t), five
// stages forming the refracted vector and its squared length, a second
// 32-stage square root for the length, one setup stage, a 17-stage
// restoring divider for normalization and the output register.
// Throughput is one transaction per cycle while the output is not stalled; every stage advances together.
// When the receiver stalls a held result, the whole pipeline freezes and
// in_i.ready drops, so nothing is lost or repeated. Reset clears every
// stage valid bit; payload registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module reflect_refract_direction_top #(
  parameter int unsigned FRAC_BITS = 14
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  rrd_in_if.sink        in_i,
  rrd_out_if.source     out_o
);

  `include "reflect_refract_direction_top_assert.svh"

  localparam int unsigned Lanes = rrd_pkg::LANES;
  localparam int unsigned WideW = rrd_pkg::WIDE_W;
  localparam int unsigned AccW  = rrd_pkg::ACC_W;
  localparam int unsigned QuotW = rrd_pkg::QUOT_W;

  localparam logic [63:0]        Half = 64'd1 << (FRAC_BITS - 1);
  localparam logic signed [35:0] OneS = 36'sd1 <<< FRAC_BITS;

  // Round half away from zero after dropping the fraction, then clamp to 32 bits.
  function automatic rrd_pkg::acc_t rnd_sat(input logic signed [63:0] x);
    logic [63:0] mag;
    logic [63:0] m;
    mag = x[63] ? (64'd0 - x) : x;
    m   = (mag + Half) >> FRAC_BITS;
    if (x[63]) begin
      rnd_sat = (m > 64'h0000_0000_8000_0000) ? 32'sh8000_0000 : 32'(64'd0 - m);
    end else begin
      rnd_sat = (m > 64'h0000_0000_7FFF_FFFF) ? 32'sh7FFF_FFFF : m[31:0];
    end
  endfunction

  function automatic rrd_pkg::acc_t sat32(input logic signed [35:0] x);
    if (x > 36'sd2147483647) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (x < -36'sd2147483648) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = x[31:0];
    end
  endfunction

  function automatic rrd_pkg::vec_t sat16(input logic signed [35:0] x);
    if (x > 36'sd32767) begin
      sat16 = 16'sh7FFF;
    end else if (x < -36'sd32768) begin
      sat16 = 16'sh8000;
    end else begin
      sat16 = x[15:0];
    end
  endfunction

  // Signed result of a normalized magnitude, clamped to the 16-bit range.
  function automatic rrd_pkg::vec_t lane_out(input logic [QuotW-1:0] q, input logic neg,
                                             input logic over);
    if (over || q >= 17'd32768) begin
      lane_out = neg ? 16'sh8000 : 16'sh7FFF;
    end else begin
      lane_out = neg ? (16'd0 - q[15:0]) : q[15:0];
    end
  endfunction

  // The whole pipeline moves when the output register is free or being taken.
  logic fo_v_q;
  logic en;
  assign en         = !fo_v_q || out_o.ready;
  assign in_i.ready = en;

  // Stage 1: dot-product terms, eta squared and eta times each incident component.
  logic                s1_v_q;
  rrd_pkg::op_e        s1_op_q;
  logic signed [33:0]  s1_dot_q;
  logic [31:0]         s1_e2_q;
  logic signed [32:0]  s1_ei_q [Lanes];
  rrd_pkg::vec_t       s1_iv_q [Lanes];
  rrd_pkg::vec_t       s1_nv_q [Lanes];
  logic [15:0]         s1_eta_q;

  rrd_pkg::vec_t       in_iv [Lanes];
  rrd_pkg::vec_t       in_nv [Lanes];
  logic signed [31:0]  in_p  [Lanes];
  logic signed [33:0]  s1_dot_d;
  logic signed [32:0]  s1_ei_d [Lanes];

  assign in_iv[0] = in_i.incident_x;
  assign in_iv[1] = in_i.incident_y;
  assign in_iv[2] = in_i.incident_z;
  assign in_nv[0] = in_i.normal_x;
  assign in_nv[1] = in_i.normal_y;
  assign in_nv[2] = in_i.normal_z;

  always_comb begin
    for (int k = 0; k < Lanes; k++) begin
      in_p[k]    = in_iv[k] * in_nv[k];
      s1_ei_d[k] = $signed({1'b0, in_i.index_ratio}) * in_iv[k];
    end
    s1_dot_d = 34'(in_p[0]) + 34'(in_p[1]) + 34'(in_p[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_op_q  <= in_i.op;
      s1_dot_q <= s1_dot_d;
      s1_e2_q  <= in_i.index_ratio * in_i.index_ratio;
      s1_eta_q <= in_i.index_ratio;
      for (int k = 0; k < Lanes; k++) begin
        s1_ei_q[k] <= s1_ei_d[k];
        s1_iv_q[k] <= in_iv[k];
        s1_nv_q[k] <= in_nv[k];
      end
    end
  end

  // Stage 2: round c = i.n, eta^2 and eta*i back to the working format.
  logic                s2_v_q;
  rrd_pkg::op_e        s2_op_q;
  rrd_pkg::acc_t       s2_c_q, s2_e2_q;
  rrd_pkg::acc_t       s2_eiq_q [Lanes];
  rrd_pkg::vec_t       s2_iv_q  [Lanes];
  rrd_pkg::vec_t       s2_nv_q  [Lanes];
  logic [15:0]         s2_eta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (en) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_op_q  <= s1_op_q;
      s2_c_q   <= rnd_sat(64'(s1_dot_q));
      s2_e2_q  <= rnd_sat(64'(s1_e2_q));
      s2_eta_q <= s1_eta_q;
      for (int k = 0; k < Lanes; k++) begin
        s2_eiq_q[k] <= rnd_sat(64'(s1_ei_q[k]));
        s2_iv_q[k]  <= s1_iv_q[k];
        s2_nv_q[k]  <= s1_nv_q[k];
      end
    end
  end

  // Stage 3: c squared, eta*c and c*n.
  logic                s3_v_q;
  rrd_pkg::op_e        s3_op_q;
  logic signed [63:0]  s3_cc_q;
  logic signed [48:0]  s3_ec_q;
  logic signed [47:0]  s3_cn_q  [Lanes];
  rrd_pkg::acc_t       s3_e2_q;
  rrd_pkg::acc_t       s3_eiq_q [Lanes];
  rrd_pkg::vec_t       s3_iv_q  [Lanes];
  rrd_pkg::vec_t       s3_nv_q  [Lanes];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (en) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_op_q <= s2_op_q;
      s3_cc_q <= s2_c_q * s2_c_q;
      s3_ec_q <= $signed({1'b0, s2_eta_q}) * s2_c_q;
      s3_e2_q <= s2_e2_q;
      for (int k = 0; k < Lanes; k++) begin
        s3_cn_q[k]  <= s2_c_q * s2_nv_q[k];
        s3_eiq_q[k] <= s2_eiq_q[k];
        s3_iv_q[k]  <= s2_iv_q[k];
        s3_nv_q[k]  <= s2_nv_q[k];
      end
    end
  end

  // Stage 4: 1 - c^2, eta*c, and the finished reflection vector.
  logic                s4_v_q;
  rrd_pkg::op_e        s4_op_q;
  rrd_pkg::acc_t       s4_om_q, s4_ec_q, s4_e2_q;
  rrd_pkg::acc_t       s4_eiq_q  [Lanes];
  rrd_pkg::vec_t       s4_nv_q   [Lanes];
  rrd_pkg::vec_t       s4_refl_q [Lanes];
  rrd_pkg::acc_t       s4_cn     [Lanes];

  always_comb begin
    for (int k = 0; k < Lanes; k++) begin
      s4_cn[k] = rnd_sat(64'(s3_cn_q[k]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_v_q <= 1'b0;
    end else if (en) begin
      s4_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_op_q <= s3_op_q;
      s4_om_q <= sat32(OneS - 36'(rnd_sat(s3_cc_q)));
      s4_ec_q <= rnd_sat(64'(s3_ec_q));
      s4_e2_q <= s3_e2_q;
      for (int k = 0; k < Lanes; k++) begin
        s4_eiq_q[k]  <= s3_eiq_q[k];
        s4_nv_q[k]   <= s3_nv_q[k];
        s4_refl_q[k] <= sat16(36'(s3_iv_q[k]) - (36'(s4_cn[k]) <<< 1));
      end
    end
  end

  // Stage 5: s = eta^2 (1 - c^2), before rounding.
  logic                s5_v_q;
  rrd_pkg::op_e        s5_op_q;
  logic signed [63:0]  s5_s_q;
  rrd_pkg::acc_t       s5_ec_q;
  rrd_pkg::acc_t       s5_eiq_q  [Lanes];
  rrd_pkg::vec_t       s5_nv_q   [Lanes];
  rrd_pkg::vec_t       s5_refl_q [Lanes];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_v_q <= 1'b0;
    end else if (en) begin
      s5_v_q <= s4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_op_q <= s4_op_q;
      s5_s_q  <= s4_e2_q * s4_om_q;
      s5_ec_q <= s4_ec_q;
      for (int k = 0; k < Lanes; k++) begin
        s5_eiq_q[k]  <= s4_eiq_q[k];
        s5_nv_q[k]   <= s4_nv_q[k];
        s5_refl_q[k] <= s4_refl_q[k];
      end
    end
  end

  // Stage 6: total internal reflection test and the radicand of cos(theta_t).
  logic                  s6_v_q;
  logic [WideW-1:0]      s6_rad_q;
  rrd_pkg::sqrt1_side_t  s6_side_q;
  rrd_pkg::sqrt1_side_t  s6_side_d;
  rrd_pkg::acc_t         s6_s, s6_r;

  always_comb begin
    s6_s = rnd_sat(s5_s_q);
    s6_r = sat32(OneS - 36'(s6_s));
    s6_side_d.tag.op  = s5_op_q;
    s6_side_d.tag.tir = (s5_op_q == rrd_pkg::OP_REFRACT) && (36'(s6_s) > OneS);
    s6_side_d.ec      = s5_ec_q;
    for (int k = 0; k < Lanes; k++) begin
      s6_side_d.tag.refl[k] = s5_refl_q[k];
      s6_side_d.eiq[k]      = s5_eiq_q[k];
      s6_side_d.nv[k]       = s5_nv_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_v_q <= 1'b0;
    end else if (en) begin
      s6_v_q <= s5_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // A negative r only occurs with total internal reflection or for reflection; its root is unused.
      s6_rad_q  <= s6_r[31] ? '0 : ({32'd0, s6_r} << FRAC_BITS);
      s6_side_q <= s6_side_d;
    end
  end

  // cos(theta_t) = isqrt((1 - s) << FRAC_BITS).
  logic                  q1_v;
  logic [WideW/2-1:0]    q1_root;
  rrd_pkg::sqrt1_side_t  q1_side;

  rrd_isqrt_pipe #(
    .Width (WideW),
    .SideW ($bits(rrd_pkg::sqrt1_side_t))
  ) u_sqrt_cos (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s6_v_q),
    .x_i     (s6_rad_q),
    .side_i  (s6_side_q),
    .valid_o (q1_v),
    .root_o  (q1_root),
    .side_o  (q1_side)
  );

  // Stage 7: k = eta*c - cos(theta_t).
  logic                s7_v_q;
  rrd_pkg::tag_t       s7_tag_q;
  rrd_pkg::acc_t       s7_kk_q;
  rrd_pkg::acc_t       s7_eiq_q [Lanes];
  rrd_pkg::vec_t       s7_nv_q  [Lanes];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s7_v_q <= 1'b0;
    end else if (en) begin
      s7_v_q <= q1_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s7_tag_q <= q1_side.tag;
      s7_kk_q  <= sat32(36'(q1_side.ec) - $signed({4'd0, q1_root}));
      for (int k = 0; k < Lanes; k++) begin
        s7_eiq_q[k] <= q1_side.eiq[k];
        s7_nv_q[k]  <= q1_side.nv[k];
      end
    end
  end

  // Stage 8: k times each normal component.
  logic                s8_v_q;
  rrd_pkg::tag_t       s8_tag_q;
  logic signed [47:0]  s8_kn_q  [Lanes];
  rrd_pkg::acc_t       s8_eiq_q [Lanes];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s8_v_q <= 1'b0;
    end else if (en) begin
      s8_v_q <= s7_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s8_tag_q <= s7_tag_q;
      for (int k = 0; k < Lanes; k++) begin
        s8_kn_q[k]  <= s7_kk_q * s7_nv_q[k];
        s8_eiq_q[k] <= s7_eiq_q[k];
      end
    end
  end

  // Stage 9: refracted vector v = eta*i + k*n.
  logic                s9_v_q;
  rrd_pkg::tag_t       s9_tag_q;
  rrd_pkg::acc_t       s9_vec_q [Lanes];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s9_v_q <= 1'b0;
    end else if (en) begin
      s9_v_q <= s8_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s9_tag_q <= s8_tag_q;
      for (int k = 0; k < Lanes; k++) begin
        s9_vec_q[k] <= sat32(36'(s8_eiq_q[k]) + 36'(rnd_sat(64'(s8_kn_q[k]))));
      end
    end
  end

  // Stage 10: squares, magnitudes and signs of the vector components.
  logic                s10_v_q;
  rrd_pkg::tag_t       s10_tag_q;
  logic [WideW-1:0]    s10_sq_q  [Lanes];
  logic [AccW-1:0]     s10_mag_q [Lanes];
  logic [Lanes-1:0]    s10_neg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s10_v_q <= 1'b0;
    end else if (en) begin
      s10_v_q <= s9_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s10_tag_q <= s9_tag_q;
      for (int k = 0; k < Lanes; k++) begin
        s10_sq_q[k]  <= s9_vec_q[k] * s9_vec_q[k];
        s10_mag_q[k] <= s9_vec_q[k][31] ? (32'd0 - s9_vec_q[k]) : s9_vec_q[k];
        s10_neg_q[k] <= s9_vec_q[k][31];
      end
    end
  end

  // Stage 11: squared length.
  logic                  s11_v_q;
  logic [WideW-1:0]      s11_len2_q;
  rrd_pkg::sqrt2_side_t  s11_side_q;
  rrd_pkg::sqrt2_side_t  s11_side_d;

  always_comb begin
    s11_side_d.tag = s10_tag_q;
    s11_side_d.neg = s10_neg_q;
    for (int k = 0; k < Lanes; k++) begin
      s11_side_d.mag[k] = s10_mag_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s11_v_q <= 1'b0;
    end else if (en) begin
      s11_v_q <= s10_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s11_len2_q <= s10_sq_q[0] + s10_sq_q[1] + s10_sq_q[2];
      s11_side_q <= s11_side_d;
    end
  end

  // Vector length.
  logic                  q2_v;
  logic [WideW/2-1:0]    q2_len;
  rrd_pkg::sqrt2_side_t  q2_side;

  rrd_isqrt_pipe #(
    .Width (WideW),
    .SideW ($bits(rrd_pkg::sqrt2_side_t))
  ) u_sqrt_len (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s11_v_q),
    .x_i     (s11_len2_q),
    .side_i  (s11_side_q),
    .valid_o (q2_v),
    .root_o  (q2_len),
    .side_o  (q2_side)
  );

  // Stage 12: rounded dividends and the overflow test for each lane.
  logic                          s12_v_q;
  logic [Lanes-1:0][WideW-1:0]   s12_num_q;
  logic [AccW-1:0]               s12_den_q;
  rrd_pkg::div_side_t            s12_side_q;
  logic [Lanes-1:0][WideW-1:0]   s12_num_d;
  rrd_pkg::div_side_t            s12_side_d;
  logic [WideW-1:0]              s12_lim;

  always_comb begin
    s12_lim = {32'd0, q2_len} << QuotW;
    s12_side_d.tag      = q2_side.tag;
    s12_side_d.neg      = q2_side.neg;
    s12_side_d.zero_len = (q2_len == '0);
    for (int k = 0; k < Lanes; k++) begin
      s12_num_d[k] = ({32'd0, q2_side.mag[k]} << FRAC_BITS) + {33'd0, q2_len[31:1]};
      s12_side_d.over[k] = (s12_num_d[k] >= s12_lim);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s12_v_q <= 1'b0;
    end else if (en) begin
      s12_v_q <= q2_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s12_num_q  <= s12_num_d;
      s12_den_q  <= q2_len;
      s12_side_q <= s12_side_d;
    end
  end

  // Normalization: each component magnitude divided by the length.
  logic                          d_v;
  logic [Lanes-1:0][QuotW-1:0]   d_quot;
  rrd_pkg::div_side_t            d_side;

  rrd_div_pipe #(
    .Lanes (Lanes),
    .NumW  (WideW),
    .DenW  (AccW),
    .QuotW (QuotW),
    .SideW ($bits(rrd_pkg::div_side_t))
  ) u_norm_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s12_v_q),
    .num_i   (s12_num_q),
    .den_i   (s12_den_q),
    .side_i  (s12_side_q),
    .valid_o (d_v),
    .quot_o  (d_quot),
    .side_o  (d_side)
  );

  // Output register: pick reflection, the flagged zero vector or the unit vector.
  rrd_pkg::vec_t  fo_vec_q [Lanes];
  logic           fo_tir_q;
  rrd_pkg::vec_t  fo_vec_d [Lanes];
  logic           fo_tir_d;

  always_comb begin
    fo_tir_d = 1'b0;
    for (int k = 0; k < Lanes; k++) begin
      if (d_side.tag.op == rrd_pkg::OP_REFLECT) begin
        fo_vec_d[k] = d_side.tag.refl[k];
      end else if (d_side.tag.tir || d_side.zero_len) begin
        fo_vec_d[k] = '0;
      end else begin
        fo_vec_d[k] = lane_out(d_quot[k], d_side.neg[k], d_side.over[k]);
      end
    end
    if (d_side.tag.op == rrd_pkg::OP_REFRACT) begin
      fo_tir_d = d_side.tag.tir;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fo_v_q <= 1'b0;
    end else if (en) begin
      fo_v_q <= d_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fo_tir_q <= fo_tir_d;
      for (int k = 0; k < Lanes; k++) begin
        fo_vec_q[k] <= fo_vec_d[k];
      end
    end
  end

  assign out_o.valid            = fo_v_q;
  assign out_o.out_x            = fo_vec_q[0];
  assign out_o.out_y            = fo_vec_q[1];
  assign out_o.out_z            = fo_vec_q[2];
  assign out_o.total_reflection = fo_tir_q;

  // High when the presented direction is the zero vector.
  logic out_zero;
  assign out_zero = (fo_vec_q[0] == '0) && (fo_vec_q[1] == '0) && (fo_vec_q[2] == '0);

  // A held result freezes the pipeline and closes the input.
  `RRD_ASSERT(a_stall_blocks_input, !(out_o.valid && !out_o.ready && in_i.ready))
  // Total internal reflection always comes with a zero direction.
  `RRD_ASSERT_IMP(a_tir_zero, out_o.valid && out_o.total_reflection, out_zero)
  // The flag raised at the Snell test survives the pipeline only for refraction.
  `RRD_ASSERT_IMP(a_tir_refract_only, d_v && d_side.tag.tir, d_side.tag.op == rrd_pkg::OP_REFRACT)

endmodule

`default_nettype wire
